// File: sv/ipap_pkg.sv
`default_nettype none

package ipap_pkg;

  localparam int POOL_DEPTH_DEF = 256;
  // used map is stored as rows of up to 2**MAP_WORD_LOG flags
  localparam int MAP_WORD_LOG = 5;

  localparam int ADDR_W = 32;
  localparam int PREFIX_W = 6;
  localparam int MAXC_W = 16;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 4;

  localparam logic [ADDR_W-1:0] BASE_RST = 32'h0000_0000;
  localparam logic [PREFIX_W-1:0] PREFIX_RST = 6'd24;
  localparam logic [MAXC_W-1:0] MAXC_RST = 16'd0;
  localparam logic [PREFIX_W-1:0] PREFIX_FULL = 6'd32;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_PREFIX = 2'd1;
  localparam logic [1:0] REG_MAXC = 2'd2;

  typedef enum logic [3:0] {
    ST_DER_A,
    ST_DER_B,
    ST_DER_C,
    ST_DER_D,
    ST_CLEAR,
    ST_IDLE,
    ST_ACQ_RD,
    ST_ACQ_CHK,
    ST_ACQ_GNT,
    ST_REL_OFF,
    ST_REL_CHK,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// File: sv/ipap_ram.sv
`default_nettype none

module ipap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/ipv4_address_pool_allocator.sv
`default_nettype none

// IPv4 address pool allocator, first free. The pool is set by base_address, prefix_bits and
// max_count (registers 0, 1, 2 at byte addresses 0, 4, 8); any register write rebuilds the
// pool and frees every address. After reset or such a write the block is busy with the pool
// derivation (states DER_A to DER_D), then with a clearing pass over the used-map RAM, one
// row a cycle. A release finds the address's offset in the pool, reads its map row and
// clears the flag if the entry lies in the pool and is set. An acquire scans the used map
// one row of up to 32 entries at a time (one RAM read port with registered read): each row
// is read, then checked, and the first free entry is marked and its address granted; with
// no free entry in the pool, or for an empty pool, it gives no grant. One 32-bit adder is
// shared by the pool derivation, the release offset and the granted address. One item is in
// work at a time; a finished result sits in an output register while the next is accepted.
module ipv4_address_pool_allocator #(
  parameter int POOL_DEPTH = ipap_pkg::POOL_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [ipap_pkg::ADDR_W-1:0]  in_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [ipap_pkg::ADDR_W-1:0]  out_granted_address,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ipap_pkg::PADDR_W-1:0] paddr,
  input  logic [ipap_pkg::DATA_W-1:0]  pwdata,
  output logic [ipap_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  import ipap_pkg::*;

  localparam int DEPTH_LOG = $clog2(POOL_DEPTH);
  localparam int BW = (MAP_WORD_LOG < DEPTH_LOG) ? MAP_WORD_LOG : DEPTH_LOG;
  localparam int WORD_W = 2 ** BW;
  localparam int ROWS = (POOL_DEPTH + WORD_W - 1) / WORD_W;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [PREFIX_W-1:0] prefix_r, prefix_nxt;
  logic [MAXC_W-1:0]   maxc_r, maxc_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [ADDR_W-1:0] mask_r, mask_nxt;
  logic              eq_net_r, eq_net_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] last_r, last_nxt;
  logic [ADDR_W-1:0] pool_first_r, pool_first_nxt;
  logic [CW-1:0]     pool_count_r, pool_count_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [BW-1:0]     bit_r, bit_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [ADDR_W-1:0] out_granted_r, out_granted_nxt;

  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic [PREFIX_W-1:0] plen;
  logic [ADDR_W-1:0] mask_c;
  logic [ADDR_W:0]   len_c;
  logic [ADDR_W:0]   cnt_pre;
  logic [CW-1:0]     cnt_sat;

  logic [ADDR_W-1:0] alu_a, alu_b, alu_sum;
  logic              alu_cin;

  logic              ram_we;
  logic [RW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [WORD_W-1:0] lim_mask, acq_avail;
  logic              acq_found;
  logic [BW-1:0]     acq_pos;
  logic              rel_hit;

  assign cfg_we = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_BASE:   prdata = base_r;
      REG_PREFIX: prdata = DATA_W'(prefix_r);
      REG_MAXC:   prdata = DATA_W'(maxc_r);
      default:    prdata = '0;
    endcase
  end

  // pool size from the registers: host span, limit, saturation at the map depth
  assign plen = (prefix_r > PREFIX_FULL) ? PREFIX_FULL : prefix_r;
  assign mask_c = ~({ADDR_W{1'b1}} >> plen);
  assign len_c = {1'b0, ~base_r & ~mask_c} + (ADDR_W + 1)'(1);
  assign cnt_pre = (maxc_r != '0 && (ADDR_W + 1)'(maxc_r) <= len_c) ?
                   (ADDR_W + 1)'(maxc_r) : len_c;
  assign cnt_sat = (cnt_pre > (ADDR_W + 1)'(POOL_DEPTH)) ? CW'(POOL_DEPTH) :
                   cnt_pre[CW-1:0];

  // shared adder
  always_comb begin
    case (state_r)
      ST_DER_B: begin
        alu_a = base_r;
        alu_b = ADDR_W'(cnt_r - 1'b1);
        alu_cin = 1'b0;
      end
      ST_DER_C: begin
        alu_a = base_r;
        alu_b = '0;
        alu_cin = 1'b1;
      end
      ST_REL_OFF: begin
        alu_a = addr_r;
        alu_b = ~pool_first_r;
        alu_cin = 1'b1;
      end
      ST_ACQ_GNT: begin
        alu_a = pool_first_r;
        alu_b = ADDR_W'({row_r, bit_r});
        alu_cin = 1'b0;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
        alu_cin = 1'b0;
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b + ADDR_W'(alu_cin);

  // flags of the current row that lie inside the pool
  assign lim_mask = (ADDR_W'(rem_r) >= ADDR_W'(WORD_W)) ? {WORD_W{1'b1}} :
                    ~({WORD_W{1'b1}} << rem_r[BW-1:0]);
  assign acq_avail = ~ram_rdata & lim_mask;
  assign acq_found = |acq_avail;

  always_comb begin
    acq_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (acq_avail[j]) acq_pos = BW'(j);
    end
  end

  assign rel_hit = (off_r < ADDR_W'(pool_count_r)) && ram_rdata[off_r[BW-1:0]];

  always_comb begin
    state_nxt = state_r;
    base_nxt = base_r;
    prefix_nxt = prefix_r;
    maxc_nxt = maxc_r;
    out_valid_nxt = out_valid_r;
    mask_nxt = mask_r;
    eq_net_nxt = eq_net_r;
    cnt_nxt = cnt_r;
    last_nxt = last_r;
    pool_first_nxt = pool_first_r;
    pool_count_nxt = pool_count_r;
    row_nxt = row_r;
    rem_nxt = rem_r;
    bit_nxt = bit_r;
    addr_nxt = addr_r;
    off_nxt = off_r;
    res_ok_nxt = res_ok_r;
    res_addr_nxt = res_addr_r;
    out_ok_nxt = out_ok_r;
    out_granted_nxt = out_granted_r;
    ram_we = 1'b0;
    ram_waddr = row_r;
    ram_wdata = '0;
    ram_raddr = row_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_DER_A: begin
        mask_nxt = mask_c;
        eq_net_nxt = (base_r & ~mask_c) == '0;
        cnt_nxt = cnt_sat;
        state_nxt = ST_DER_B;
      end
      ST_DER_B: begin
        last_nxt = alu_sum;
        state_nxt = ST_DER_C;
      end
      ST_DER_C: begin
        // base on the network address: step over it
        if (eq_net_r) begin
          pool_first_nxt = alu_sum;
          pool_count_nxt = (cnt_r == '0) ? '0 : cnt_r - 1'b1;
        end else begin
          pool_first_nxt = base_r;
          pool_count_nxt = cnt_r;
        end
        state_nxt = ST_DER_D;
      end
      ST_DER_D: begin
        // last entry on the broadcast address: drop it
        if (last_r == (pool_first_r | ~mask_r)) begin
          pool_count_nxt = (pool_count_r == '0) ? '0 : pool_count_r - 1'b1;
        end
        row_nxt = '0;
        state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = row_r;
        ram_wdata = '0;
        if (row_r == RW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          addr_nxt = in_address;
          if (in_cmd == CMD_RELEASE) begin
            state_nxt = ST_REL_OFF;
          end else if (pool_count_r == '0) begin
            res_ok_nxt = 1'b0;
            res_addr_nxt = '0;
            state_nxt = ST_RESP;
          end else begin
            row_nxt = '0;
            rem_nxt = pool_count_r;
            state_nxt = ST_ACQ_RD;
          end
        end
      end
      ST_ACQ_RD: begin
        ram_raddr = row_r;
        state_nxt = ST_ACQ_CHK;
      end
      ST_ACQ_CHK: begin
        if (acq_found) begin
          ram_we = 1'b1;
          ram_waddr = row_r;
          ram_wdata = ram_rdata | (WORD_W'(1) << acq_pos);
          bit_nxt = acq_pos;
          state_nxt = ST_ACQ_GNT;
        end else if (ADDR_W'(rem_r) <= ADDR_W'(WORD_W)) begin
          res_ok_nxt = 1'b0;
          res_addr_nxt = '0;
          state_nxt = ST_RESP;
        end else begin
          row_nxt = row_r + 1'b1;
          rem_nxt = rem_r - CW'(WORD_W);
          state_nxt = ST_ACQ_RD;
        end
      end
      ST_ACQ_GNT: begin
        res_ok_nxt = 1'b1;
        res_addr_nxt = alu_sum;
        state_nxt = ST_RESP;
      end
      ST_REL_OFF: begin
        off_nxt = alu_sum;
        ram_raddr = alu_sum[BW +: RW];
        state_nxt = ST_REL_CHK;
      end
      ST_REL_CHK: begin
        if (rel_hit) begin
          ram_we = 1'b1;
          ram_waddr = off_r[BW +: RW];
          ram_wdata = ram_rdata & ~(WORD_W'(1) << off_r[BW-1:0]);
        end
        res_ok_nxt = rel_hit;
        res_addr_nxt = '0;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt = res_ok_r;
          out_granted_nxt = res_addr_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_DER_A;
      end
    endcase

    // register write: rebuild the pool and sweep the map
    if (cfg_we) begin
      case (cfg_idx)
        REG_BASE: begin
          base_nxt = pwdata;
          state_nxt = ST_DER_A;
        end
        REG_PREFIX: begin
          prefix_nxt = pwdata[PREFIX_W-1:0];
          state_nxt = ST_DER_A;
        end
        REG_MAXC: begin
          maxc_nxt = pwdata[MAXC_W-1:0];
          state_nxt = ST_DER_A;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DER_A;
      base_r <= BASE_RST;
      prefix_r <= PREFIX_RST;
      maxc_r <= MAXC_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r <= base_nxt;
      prefix_r <= prefix_nxt;
      maxc_r <= maxc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    eq_net_r <= eq_net_nxt;
    cnt_r <= cnt_nxt;
    last_r <= last_nxt;
    pool_first_r <= pool_first_nxt;
    pool_count_r <= pool_count_nxt;
    row_r <= row_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    addr_r <= addr_nxt;
    off_r <= off_nxt;
    res_ok_r <= res_ok_nxt;
    res_addr_r <= res_addr_nxt;
    out_ok_r <= out_ok_nxt;
    out_granted_r <= out_granted_nxt;
  end

  ipap_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_used_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_ok = out_ok_r;
  assign out_granted_address = out_granted_r;

`ifndef SYNTHESIS
  a_no_map_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("used map written while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not start work");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESP))
    else $error("result raised outside response state");

  a_scan_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACQ_CHK) |-> (rem_r != '0))
    else $error("map row scanned beyond the pool");

  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACQ_GNT) |-> (ADDR_W'({row_r, bit_r}) < ADDR_W'(pool_count_r)))
    else $error("granted entry outside the pool");
`endif

endmodule

`default_nettype wire
